@@ src/chs_pkg.sv @@
// Shared constants, types and helpers for the chained hash set block.
`timescale 1ns / 1ps

package chs_pkg;

   // Default geometry of the node store
   localparam int DEF_TABLE_NODES = 16;
   localparam int DEF_BUCKETS     = 8;

   // Stream widths
   localparam int KEY_W = 8;
   localparam int RSP_W = 8;

   // Result bit positions inside rsp_tdata
   localparam int RSP_FOUND_BIT  = 0;
   localparam int RSP_STORED_BIT = 1;
   localparam int RSP_FULL_BIT   = 2;

   // Character constants used by the hash
   localparam logic [KEY_W-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [KEY_W-1:0] CHAR_LO_A   = 8'h61;
   localparam logic [KEY_W-1:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [KEY_W-1:0] CASE_OFFSET = 8'h20;

   // Request kind carried on req_tuser
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   // Fold a-z to upper case, then subtract 'A' modulo 256
   function automatic logic [KEY_W-1:0] hash_base(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] u;
      u = k;
      if (k >= CHAR_LO_A && k <= CHAR_LO_Z) begin
         u = k - CASE_OFFSET;
      end
      return u - CHAR_UP_A;
   endfunction

endpackage

@@ src/chained_hash_set_with_overflow_top.sv @@
// Chained hash set of byte keys with primary and overflow node areas.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_*): one transaction per request. req_tuser selects
//   insert (0) or lookup (1); req_tdata carries the key byte.
//   Response channel (rsp_*): exactly one transaction per request, in order.
//   rsp_tdata bit 0 found, bit 1 stored, bit 2 full (insert had no free node).
// Timing
//   One request at a time; req_tready is high only while the block is idle.
//   The bucket index comes from a reciprocal multiply in S_HASH. The chain
//   walk then reads one node per cycle, L nodes (1 .. 1 + TABLE_NODES -
//   BUCKETS). After the walk a miss passes through S_UPDATE, and an insert
//   that appends an overflow node also through S_LINK; S_DONE then loads
//   the response register when it is free, and the next request is taken
//   once the block is back in S_IDLE.
// Reset
//   Synchronous, active high. All home slots read empty and the overflow
//   area is free at once; no clearing pass is needed.
// Stall
//   The response sits in an output register. While rsp_tready is low a
//   finished request holds there, the next request may still be accepted,
//   and its own result waits inside until the output register frees up.
module chained_hash_set_with_overflow_top #(
   parameter int TABLE_NODES = chs_pkg::DEF_TABLE_NODES,
   parameter int BUCKETS     = chs_pkg::DEF_BUCKETS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [chs_pkg::KEY_W-1:0]  req_tdata,   // [7:0] key
   input  logic                       req_tuser,   // [0] req_type
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [chs_pkg::RSP_W-1:0]  rsp_tdata    // [0] found, [1] stored, [2] full_res
);
   import chs_pkg::*;

   // Store geometry
   localparam int STORE_SZ = (TABLE_NODES > BUCKETS) ? TABLE_NODES : BUCKETS;
   localparam int LW = $clog2(STORE_SZ + 1);
   localparam int IW = $clog2(STORE_SZ);
   localparam int BW = $clog2(BUCKETS);
   localparam int RW = BW + 1;
   localparam logic [LW-1:0] NIL_LINK  = LW'(STORE_SZ);
   localparam logic [LW-1:0] FREE_INIT = (BUCKETS < TABLE_NODES) ? LW'(BUCKETS) : NIL_LINK;
   localparam logic [RW-1:0] BUCKETS_R = RW'(BUCKETS);

   // Reciprocal of BUCKETS, exact for every 8-bit dividend while BUCKETS <= 128
   localparam int RECIP_SH = 16;
   localparam logic [RECIP_SH-1:0] RECIP_M = RECIP_SH'((2**RECIP_SH + BUCKETS - 1) / BUCKETS);
   localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_CHECK,
      S_UPDATE,
      S_LINK,
      S_DONE
   } state_type;

   // Control and datapath registers
   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   req_kind_type       kind_ff, kind_in;
   logic [KEY_W-1:0]   div_ff, div_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [IW-1:0]      new_ff, new_in;
   logic               first_ff, first_in;
   logic               found_ff, found_in;
   logic               stored_ff, stored_in;
   logic               full_ff, full_in;
   logic [LW-1:0]      free_head_ff, free_head_in;
   logic [BUCKETS-1:0] home_used_ff, home_used_in;
   logic [BUCKETS-1:0] link_valid_ff, link_valid_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // Node store
   logic [KEY_W-1:0] key_mem [STORE_SZ];
   logic [LW-1:0]    link_mem [STORE_SZ];
   logic [KEY_W-1:0] key_rd_ff;
   logic [LW-1:0]    link_rd_ff;
   logic             key_we, link_we;
   logic [IW-1:0]    key_waddr, link_waddr;
   logic [LW-1:0]    link_wdata;

   // Combinational helpers
   logic [BW-1:0]              bucket;
   logic [KEY_W+RECIP_SH-1:0]  recip_prod;
   logic [KEY_W-1:0]           quot;
   logic [KEY_W-1:0]           rem_full;
   logic                       hit;
   logic                       link_ok;
   logic                       chain_end;
   logic [LW:0]                free_next;

   assign bucket     = rem_ff[BW-1:0];
   assign recip_prod = (KEY_W+RECIP_SH)'(div_ff) * (KEY_W+RECIP_SH)'(RECIP_M);
   assign quot       = recip_prod[KEY_W+RECIP_SH-1:RECIP_SH];
   assign rem_full   = div_ff - quot * BUCKETS_K;
   assign hit        = (key_rd_ff == key_ff) && (!first_ff || home_used_ff[bucket]);
   assign link_ok    = first_ff ? link_valid_ff[bucket] : 1'b1;
   assign chain_end  = !link_ok || (link_rd_ff >= NIL_LINK);
   assign free_next  = {1'b0, free_head_ff} + (LW+1)'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      kind_in       = kind_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      new_in        = new_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      stored_in     = stored_ff;
      full_in       = full_ff;
      free_head_in  = free_head_ff;
      home_used_in  = home_used_ff;
      link_valid_in = link_valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      key_we        = 1'b0;
      key_waddr     = cur_ff;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = NIL_LINK;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in    = req_tdata;
               kind_in   = req_kind_type'(req_tuser);
               div_in    = hash_base(req_tdata);
               found_in  = 1'b0;
               stored_in = 1'b0;
               full_in   = 1'b0;
               state_in  = S_HASH;
            end
         end
         // Bucket index from the reciprocal multiply
         S_HASH: begin
            rem_in   = rem_full[RW-1:0];
            cur_in   = IW'(rem_full[BW-1:0]);
            first_in = 1'b1;
            state_in = S_CHECK;
         end
         // One chain node per cycle; read data belongs to cur_ff
         S_CHECK: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else begin
               tail_in = cur_ff;
               if (chain_end) begin
                  state_in = S_UPDATE;
               end else begin
                  cur_in   = link_rd_ff[IW-1:0];
                  first_in = 1'b0;
               end
            end
         end
         S_UPDATE: begin
            state_in = S_DONE;
            if (kind_ff == REQ_INSERT) begin
               if (!home_used_ff[bucket]) begin
                  key_we               = 1'b1;
                  key_waddr            = IW'(bucket);
                  home_used_in[bucket] = 1'b1;
                  stored_in            = 1'b1;
               end else if (free_head_ff >= NIL_LINK) begin
                  full_in = 1'b1;
               end else begin
                  // Take the free head; the free list runs in index order
                  key_we     = 1'b1;
                  key_waddr  = free_head_ff[IW-1:0];
                  link_we    = 1'b1;
                  link_waddr = free_head_ff[IW-1:0];
                  link_wdata = NIL_LINK;
                  new_in     = free_head_ff[IW-1:0];
                  if (free_next < (LW+1)'(TABLE_NODES)) begin
                     free_head_in = free_next[LW-1:0];
                  end else begin
                     free_head_in = NIL_LINK;
                  end
                  state_in = S_LINK;
               end
            end
         end
         // Hook the new node onto the chain tail
         S_LINK: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = LW'(new_ff);
            stored_in  = 1'b1;
            if (int'(tail_ff) < BUCKETS) begin
               link_valid_in[tail_ff[BW-1:0]] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in                = 1'b1;
               rsp_tdata_in                 = '0;
               rsp_tdata_in[RSP_FOUND_BIT]  = found_ff;
               rsp_tdata_in[RSP_STORED_BIT] = stored_ff;
               rsp_tdata_in[RSP_FULL_BIT]   = full_ff;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= FREE_INIT;
         home_used_ff  <= '0;
         link_valid_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         first_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         home_used_ff  <= home_used_in;
         link_valid_ff <= link_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         first_ff      <= first_in;
      end
      key_ff       <= key_in;
      kind_ff      <= kind_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cur_ff       <= cur_in;
      tail_ff      <= tail_in;
      new_ff       <= new_in;
      found_ff     <= found_in;
      stored_ff    <= stored_in;
      full_ff      <= full_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Node store: one write port per array, registered read at the next node
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      key_rd_ff  <= key_mem[cur_in];
      link_rd_ff <= link_mem[cur_in];
   end

   // Checks
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (rem_ff < BUCKETS_R))
      else $error("bucket remainder out of range");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !(found_ff && stored_ff) && !(stored_ff && full_ff)
                               && !(found_ff && full_ff))
      else $error("conflicting result flags");

   a_lookup_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && kind_ff == REQ_LOOKUP) |-> !stored_ff && !full_ff)
      else $error("lookup reported a store or full");

   a_free_head_moves_on_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && !$stable(free_head_ff)) |->
         ($past(state_ff) == S_UPDATE && state_ff == S_LINK))
      else $error("free head moved outside an append");

   a_full_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && full_ff) |-> (free_head_ff == NIL_LINK))
      else $error("full reported with free nodes left");

endmodule
